// ===== hw/rtl/btpm_pkg.sv =====
`default_nettype none
package btpm_pkg;

    localparam int ADDR_BITS  = 32;
    localparam int NODE_COUNT = 4096;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int FREE_W     = $clog2(NODE_COUNT + 1);
    localparam int LEN_W      = $clog2(ADDR_BITS + 1);

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0]     child1;
        logic [IDX_W-1:0]     child0;
        logic                 valid;
        logic [ADDR_BITS-1:0] addr;
        logic [LEN_W-1:0]     len;
    } node_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic last;
    } stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/btpm_ctrl.sv =====
`default_nettype none
module btpm_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire btpm_pkg::stat_t stat,
    output btpm_pkg::cmd_t      cmd,
    output logic                busy,
    output logic                done
);

    btpm_pkg::state_t state_reg;
    btpm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= btpm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            btpm_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = btpm_pkg::ST_WALK;
                end
            end
            btpm_pkg::ST_WALK:
            begin
                cmd.step = 1'b1;
                if (stat.last)
                begin
                    state_next = btpm_pkg::ST_DONE;
                end
            end
            btpm_pkg::ST_DONE:
            begin
                done       = 1'b1;
                state_next = btpm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = btpm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/btpm_datapath.sv =====
`default_nettype none
module btpm_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire btpm_pkg::cmd_t                 cmd,
    input  wire logic                           mode,
    input  wire logic [btpm_pkg::ADDR_BITS-1:0] key_addr,
    input  wire logic [btpm_pkg::LEN_W-1:0]     prefix_len,
    output btpm_pkg::stat_t                     stat,
    output logic                                found,
    output logic [btpm_pkg::ADDR_BITS-1:0]      match_addr,
    output logic [btpm_pkg::LEN_W-1:0]          match_len,
    output logic                                status
);

    btpm_pkg::node_t mem [btpm_pkg::NODE_COUNT];
    btpm_pkg::node_t mem_q;

    btpm_pkg::node_t                  root_reg;
    logic [btpm_pkg::FREE_W-1:0]      next_free_reg;
    logic                             mode_reg;
    logic [btpm_pkg::ADDR_BITS-1:0]   key_reg;
    logic [btpm_pkg::ADDR_BITS-1:0]   shift_reg;
    logic [btpm_pkg::LEN_W-1:0]       plen_reg;
    logic [btpm_pkg::LEN_W-1:0]       depth_reg;
    btpm_pkg::node_t                  cur_reg;
    logic [btpm_pkg::IDX_W-1:0]       cur_idx_reg;
    logic                             cur_root_reg;
    logic                             use_mem_reg;
    logic                             hit_reg;
    logic [btpm_pkg::ADDR_BITS-1:0]   best_addr_reg;
    logic [btpm_pkg::LEN_W-1:0]       best_len_reg;
    logic                             found_reg;
    logic [btpm_pkg::ADDR_BITS-1:0]   match_addr_reg;
    logic [btpm_pkg::LEN_W-1:0]       match_len_reg;
    logic                             status_reg;

    btpm_pkg::node_t                  cur;
    btpm_pkg::node_t                  wr_data;
    logic                             bit_sel;
    logic [btpm_pkg::IDX_W-1:0]       child;
    logic                             child_zero;
    logic                             full;
    logic [btpm_pkg::ADDR_BITS-1:0]   mask;
    logic                             addr_match;
    logic                             wr_en;
    logic                             rd_en;
    logic                             descend;
    logic                             alloc;
    logic                             fail;
    logic                             hit_now;
    logic                             last;
    logic                             hit_next;
    logic [btpm_pkg::ADDR_BITS-1:0]   best_addr_next;
    logic [btpm_pkg::LEN_W-1:0]       best_len_next;
    logic [btpm_pkg::LEN_W-1:0]       plen_sat;

    assign plen_sat = (prefix_len > btpm_pkg::LEN_W'(btpm_pkg::ADDR_BITS))
                    ? btpm_pkg::LEN_W'(btpm_pkg::ADDR_BITS) : prefix_len;

    always_comb
    begin
        cur        = use_mem_reg ? mem_q : cur_reg;
        bit_sel    = shift_reg[btpm_pkg::ADDR_BITS-1];
        child      = bit_sel ? cur.child1 : cur.child0;
        child_zero = (child == '0);
        full       = (next_free_reg == btpm_pkg::FREE_W'(btpm_pkg::NODE_COUNT));
        mask       = ~({btpm_pkg::ADDR_BITS{1'b1}} >> cur.len);
        addr_match = (((key_reg ^ cur.addr) & mask) == '0);
        wr_data    = cur;
        wr_en      = 1'b0;
        descend    = 1'b0;
        alloc      = 1'b0;
        fail       = 1'b0;
        hit_now    = 1'b0;
        last       = 1'b0;
        if (mode_reg == btpm_pkg::MODE_INSERT)
        begin
            if (depth_reg == plen_reg)
            begin
                wr_en         = 1'b1;
                wr_data.valid = 1'b1;
                wr_data.addr  = key_reg;
                wr_data.len   = plen_reg;
                last          = 1'b1;
            end
            else if (!child_zero)
            begin
                descend = 1'b1;
            end
            else if (full)
            begin
                // write back so a fresh node on the path is left empty, not unwritten
                wr_en = 1'b1;
                fail  = 1'b1;
                last  = 1'b1;
            end
            else
            begin
                wr_en = 1'b1;
                alloc = 1'b1;
                if (bit_sel)
                begin
                    wr_data.child1 = next_free_reg[btpm_pkg::IDX_W-1:0];
                end
                else
                begin
                    wr_data.child0 = next_free_reg[btpm_pkg::IDX_W-1:0];
                end
            end
        end
        else
        begin
            if (cur.valid && !addr_match)
            begin
                last = 1'b1;
            end
            else
            begin
                hit_now = cur.valid;
                if ((depth_reg == btpm_pkg::LEN_W'(btpm_pkg::ADDR_BITS)) || child_zero)
                begin
                    last = 1'b1;
                end
                else
                begin
                    descend = 1'b1;
                end
            end
        end
        wr_en          = wr_en & cmd.step;
        rd_en          = descend & cmd.step;
        hit_next       = hit_reg | hit_now;
        best_addr_next = hit_now ? cur.addr : best_addr_reg;
        best_len_next  = hit_now ? cur.len : best_len_reg;
        stat.last      = last;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !cur_root_reg)
        begin
            mem[cur_idx_reg] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q <= mem[child];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg       <= '0;
            next_free_reg  <= btpm_pkg::FREE_W'(1);
            mode_reg       <= btpm_pkg::MODE_INSERT;
            key_reg        <= '0;
            shift_reg      <= '0;
            plen_reg       <= '0;
            depth_reg      <= '0;
            cur_reg        <= '0;
            cur_idx_reg    <= '0;
            cur_root_reg   <= 1'b1;
            use_mem_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            best_addr_reg  <= '0;
            best_len_reg   <= '0;
            found_reg      <= 1'b0;
            match_addr_reg <= '0;
            match_len_reg  <= '0;
            status_reg     <= btpm_pkg::STATUS_OK;
        end
        else if (cmd.load)
        begin
            mode_reg      <= mode;
            key_reg       <= key_addr;
            shift_reg     <= key_addr;
            plen_reg      <= plen_sat;
            depth_reg     <= '0;
            cur_reg       <= root_reg;
            cur_root_reg  <= 1'b1;
            use_mem_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            best_addr_reg <= '0;
            best_len_reg  <= '0;
        end
        else if (cmd.step)
        begin
            if (wr_en && cur_root_reg)
            begin
                root_reg <= wr_data;
            end
            if (descend)
            begin
                cur_idx_reg  <= child;
                cur_root_reg <= 1'b0;
                use_mem_reg  <= 1'b1;
                depth_reg    <= depth_reg + btpm_pkg::LEN_W'(1);
                shift_reg    <= shift_reg << 1;
            end
            if (alloc)
            begin
                cur_reg       <= '0;
                cur_idx_reg   <= next_free_reg[btpm_pkg::IDX_W-1:0];
                cur_root_reg  <= 1'b0;
                use_mem_reg   <= 1'b0;
                depth_reg     <= depth_reg + btpm_pkg::LEN_W'(1);
                shift_reg     <= shift_reg << 1;
                next_free_reg <= next_free_reg + btpm_pkg::FREE_W'(1);
            end
            hit_reg       <= hit_next;
            best_addr_reg <= best_addr_next;
            best_len_reg  <= best_len_next;
            if (last)
            begin
                if (mode_reg == btpm_pkg::MODE_INSERT)
                begin
                    found_reg      <= 1'b0;
                    match_addr_reg <= '0;
                    match_len_reg  <= '0;
                    status_reg     <= fail ? btpm_pkg::STATUS_FULL : btpm_pkg::STATUS_OK;
                end
                else
                begin
                    found_reg      <= hit_next;
                    match_addr_reg <= best_addr_next;
                    match_len_reg  <= best_len_next;
                    status_reg     <= btpm_pkg::STATUS_OK;
                end
            end
        end
    end

    assign found      = found_reg;
    assign match_addr = match_addr_reg;
    assign match_len  = match_len_reg;
    assign status     = status_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/binary_trie_prefix_match_core.sv =====
// an insert of length n or a lookup that walks d levels makes one node memory read or write
// per trie level
// one word at a time: busy rises after the accepted start and stays high through done
// the result is valid in the single cycle that done is high; the receiver cannot stall
// reset: asynchronous active-low rst_n empties the root and sets the next free node to one
// with no clearing pass, so the block is ready right after reset
`default_nettype none
module binary_trie_prefix_match_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           mode,
    input  wire logic [btpm_pkg::ADDR_BITS-1:0] key_addr,
    input  wire logic [btpm_pkg::LEN_W-1:0]     prefix_len,
    output logic                                done,
    output logic                                found,
    output logic [btpm_pkg::ADDR_BITS-1:0]      match_addr,
    output logic [btpm_pkg::LEN_W-1:0]          match_len,
    output logic                                status
);

    btpm_pkg::cmd_t  cmd;
    btpm_pkg::stat_t stat;

    btpm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    btpm_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .mode       (mode),
        .key_addr   (key_addr),
        .prefix_len (prefix_len),
        .stat       (stat),
        .found      (found),
        .match_addr (match_addr),
        .match_len  (match_len),
        .status     (status)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/btpm_checker.sv =====
`default_nettype none
module btpm_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           start,
    input wire logic                           busy,
    input wire logic                           done,
    input wire logic                           found,
    input wire logic [btpm_pkg::ADDR_BITS-1:0] match_addr,
    input wire logic [btpm_pkg::LEN_W-1:0]     match_len,
    input wire logic                           status
);

    // a result only belongs to an accepted word
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done without busy");

    assert property (@(posedge clk) disable iff (!rst_n) start && !busy |=> busy && !done)
        else $error("accepted word not held busy");

    assert property (@(posedge clk) disable iff (!rst_n) done |=> !busy && !done)
        else $error("busy not released after done");

    // a failed insert reports no match
    assert property (@(posedge clk) disable iff (!rst_n)
        done && status |-> !found && match_addr == '0 && match_len == '0)
        else $error("full status with match data");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> match_len <= btpm_pkg::LEN_W'(btpm_pkg::ADDR_BITS)
                 && (found || (match_addr == '0 && match_len == '0)))
        else $error("bad match fields");

endmodule

bind binary_trie_prefix_match_core btpm_checker u_btpm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .found      (found),
    .match_addr (match_addr),
    .match_len  (match_len),
    .status     (status)
);
`default_nettype wire
